/* rtl/bsp_pkg.sv */
`default_nettype none
package bsp_pkg;

   // sizes
   localparam int MAX_POINTS = 32;
   localparam int MAX_DEGREE = 7;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_W      = 34;
   localparam int CNT_W      = 6;

   localparam logic [16:0] ONE = 17'h10000;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_EVAL  = 2'd1;
   localparam logic [1:0] MODE_BASIS = 2'd2;

   // register indexes
   localparam logic CSR_DEGREE = 1'b0;
   localparam logic CSR_COUNT  = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [4:0]         point_index;
      logic signed [23:0] point_value;
      logic [16:0]        x_pos;
   } req_type;

   typedef struct packed {
      logic signed [31:0] curve_value;
      logic [16:0]        basis_value;
      logic [4:0]         basis_index;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [16:0]       den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [NUM_W-1:0]  quot;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_KNOT, S_SPAN, S_TA, S_TB, S_TC, S_TD, S_M1, S_M2,
      S_DGO, S_DWAIT, S_UPD, S_SUMM, S_SUMA, S_SUMOUT, S_RSP, S_EMIT, S_EWAIT
   } state_type;

   typedef enum logic [1:0] {
      PH_KNOT, PH_T1, PH_T2
   } phase_type;

endpackage
`default_nettype wire

/* rtl/clamped_bspline_evaluator.sv */
`default_nettype none
// Clamped uniform B-spline evaluator on [0,1].
// Requests arrive on req_* (valid/stall); results leave on rsp_* (valid/stall).
// degree and control_count are written through csr_we/csr_index/csr_wdata
// while the block is idle, a rule on the user that the block does not enforce;
// a write drops the cached interior knots. A write request (mode 0) stores one
// control point, no result. An evaluate request (mode 1) gives one result;
// a basis request (mode 2) gives control_count results (clamped to 1..32), last
// set on the final one. After a register write, the interior knots are rebuilt
// on the next evaluate or basis request, one divide per knot through the
// shared divider. The span search steps past one knot at a time, and each of
// the p(p+3)/2 recursion terms reads four knots, multiplies and takes up to two
// divides (at most p(p+1) divides in all). The curve sum then multiplies and
// adds once per point in the window; each basis result is held until taken.
// req_stall is high from acceptance of an evaluate or basis request until the
// last result is taken; a stalled result holds in its output register.
// Synchronous reset clears the control point table, restores degree 3 and 8
// points and leaves the block idle.
module clamped_bspline_evaluator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bsp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bsp_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [5:0]       csr_wdata
);

   bsp_pkg::state_type  state_ff, state_in;
   bsp_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]          degree_ff;
   logic [5:0]          count_ff;
   logic                kvalid_ff, kvalid_in;
   logic [16:0]         kt_ff [bsp_pkg::MAX_POINTS];
   logic [16:0]         kt_in;
   logic                kt_we;
   logic signed [23:0]  table_ff [bsp_pkg::MAX_POINTS];
   logic                tbl_we;
   logic [1:0]          mode_ff, mode_in;
   logic [16:0]         x_ff, x_in;
   logic [4:0]          s_ff, s_in, e_ff, e_in;
   logic [5:0]          k_ff, k_in;
   logic [2:0]          j_ff, j_in, kk_ff, kk_in;
   logic [16:0]         ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in, td_ff, td_in;
   logic [16:0]         loc_ff [8];
   logic [16:0]         loc_in [8];
   logic [34:0]         vsum_ff, vsum_in;
   logic signed [42:0]  prod_ff, prod_in;
   logic [16:0]         den_ff, den_in;
   logic signed [45:0]  acc_ff, acc_in;
   bsp_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [5:0]          n_eff, nm1;
   logic [2:0]          p_eff;
   logic [4:0]          m_eff;
   logic [5:0]          base, iidx, kaddr, kaddr_m;
   logic [16:0]         kval, hval, gval;
   logic                cond1, cond2, accept, last_term, last_level;
   logic signed [24:0]  mul_a;
   logic signed [17:0]  mul_b;
   logic signed [42:0]  mul_p;
   logic signed [45:0]  q_sh;
   logic [5:0]          ediff;
   logic [16:0]         ebasis;
   bsp_pkg::div_req_type div_req;
   bsp_pkg::div_rsp_type div_rsp;

   bsp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // effective point count, degree and interior knot count
   always_comb begin
      if (count_ff == 0) n_eff = 6'd1;
      else if (count_ff > 6'(bsp_pkg::MAX_POINTS)) n_eff = 6'(bsp_pkg::MAX_POINTS);
      else n_eff = count_ff;
      nm1   = n_eff - 6'd1;
      p_eff = (nm1 < {3'b0, degree_ff}) ? nm1[2:0] : degree_ff;
      m_eff = 5'(n_eff - {3'b0, p_eff} - 6'd1);
   end

   // knot read port, one address a cycle chosen by the sequencer
   always_comb begin
      base = {1'b0, s_ff} - {3'b0, p_eff};
      iidx = base + {3'b0, kk_ff};
      case (state_ff)
         bsp_pkg::S_SPAN: kaddr = {1'b0, s_ff} + 6'd1;
         bsp_pkg::S_TA:   kaddr = iidx;
         bsp_pkg::S_TB:   kaddr = iidx + {3'b0, j_ff};
         bsp_pkg::S_TC:   kaddr = iidx + 6'd1;
         bsp_pkg::S_TD:   kaddr = iidx + {3'b0, j_ff} + 6'd1;
         default:         kaddr = '0;
      endcase
      kaddr_m = kaddr - {3'b0, p_eff} - 6'd1;
      if (kaddr <= {3'b0, p_eff}) kval = '0;
      else if (kaddr >= n_eff) kval = bsp_pkg::ONE;
      else kval = kt_ff[kaddr_m[4:0]];
   end

   // recursion terms and the shared multiplier
   always_comb begin
      hval  = loc_ff[kk_ff];
      gval  = (kk_ff < p_eff) ? loc_ff[3'(kk_ff + 3'd1)] : '0;
      cond1 = (hval != 0) && (tb_ff > ta_ff) && (x_ff >= ta_ff);
      cond2 = (gval != 0) && (td_ff > tc_ff) && (td_ff >= x_ff);
      case (state_ff)
         bsp_pkg::S_M1: begin
            mul_a = {8'b0, 17'(x_ff - ta_ff)};
            mul_b = {1'b0, hval};
         end
         bsp_pkg::S_M2: begin
            mul_a = {8'b0, 17'(td_ff - x_ff)};
            mul_b = {1'b0, gval};
         end
         default: begin
            mul_a = {table_ff[iidx[4:0]][23], table_ff[iidx[4:0]]};
            mul_b = {1'b0, hval};
         end
      endcase
      mul_p      = mul_a * mul_b;
      last_term  = (kk_ff == p_eff);
      last_level = (j_ff == p_eff);
      accept     = req_valid && !req_stall;
      q_sh       = acc_ff >>> bsp_pkg::FRAC_BITS;
      ediff      = {1'b0, e_ff} - base;
      ebasis     = ({1'b0, e_ff} >= base && ediff <= {3'b0, p_eff}) ? loc_ff[ediff[2:0]] : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsp_pkg::S_IDLE:
            if (accept && (req_data.mode == bsp_pkg::MODE_EVAL ||
                           req_data.mode == bsp_pkg::MODE_BASIS))
               state_in = kvalid_ff ? bsp_pkg::S_SPAN : bsp_pkg::S_KNOT;
         bsp_pkg::S_KNOT:
            state_in = (k_ff > {1'b0, m_eff}) ? bsp_pkg::S_SPAN : bsp_pkg::S_DGO;
         bsp_pkg::S_SPAN:
            if (!({1'b0, s_ff} < nm1 && kval <= x_ff)) begin
               if (p_eff == 0)
                  state_in = (mode_ff == bsp_pkg::MODE_EVAL) ? bsp_pkg::S_SUMM : bsp_pkg::S_EMIT;
               else
                  state_in = bsp_pkg::S_TA;
            end
         bsp_pkg::S_TA: state_in = bsp_pkg::S_TB;
         bsp_pkg::S_TB: state_in = bsp_pkg::S_TC;
         bsp_pkg::S_TC: state_in = bsp_pkg::S_TD;
         bsp_pkg::S_TD: state_in = bsp_pkg::S_M1;
         bsp_pkg::S_M1: state_in = cond1 ? bsp_pkg::S_DGO : bsp_pkg::S_M2;
         bsp_pkg::S_M2: state_in = cond2 ? bsp_pkg::S_DGO : bsp_pkg::S_UPD;
         bsp_pkg::S_DGO: state_in = bsp_pkg::S_DWAIT;
         bsp_pkg::S_DWAIT:
            if (div_rsp.done) begin
               unique case (phase_ff)
                  bsp_pkg::PH_KNOT: state_in = bsp_pkg::S_KNOT;
                  bsp_pkg::PH_T1:   state_in = bsp_pkg::S_M2;
                  default:          state_in = bsp_pkg::S_UPD;
               endcase
            end
         bsp_pkg::S_UPD:
            if (last_term && last_level)
               state_in = (mode_ff == bsp_pkg::MODE_EVAL) ? bsp_pkg::S_SUMM : bsp_pkg::S_EMIT;
            else
               state_in = bsp_pkg::S_TA;
         bsp_pkg::S_SUMM: state_in = bsp_pkg::S_SUMA;
         bsp_pkg::S_SUMA: state_in = last_term ? bsp_pkg::S_SUMOUT : bsp_pkg::S_SUMM;
         bsp_pkg::S_SUMOUT: state_in = bsp_pkg::S_RSP;
         bsp_pkg::S_RSP: if (!rsp_stall) state_in = bsp_pkg::S_IDLE;
         bsp_pkg::S_EMIT: state_in = bsp_pkg::S_EWAIT;
         bsp_pkg::S_EWAIT:
            if (!rsp_stall) state_in = rsp_ff.last ? bsp_pkg::S_IDLE : bsp_pkg::S_EMIT;
         default: state_in = bsp_pkg::S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      phase_in     = phase_ff;
      kvalid_in    = kvalid_ff;
      kt_in        = div_rsp.quot[16:0];
      kt_we        = 1'b0;
      tbl_we       = 1'b0;
      mode_in      = mode_ff;
      x_in         = x_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      j_in         = j_ff;
      kk_in        = kk_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      tc_in        = tc_ff;
      td_in        = td_ff;
      loc_in       = loc_ff;
      vsum_in      = vsum_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      div_req      = '{start: 1'b0, num: prod_ff[bsp_pkg::NUM_W-1:0], den: den_ff};
      unique case (state_ff)
         bsp_pkg::S_IDLE:
            if (accept) begin
               tbl_we  = (req_data.mode == bsp_pkg::MODE_WRITE);
               mode_in = req_data.mode;
               x_in    = (req_data.x_pos > bsp_pkg::ONE) ? bsp_pkg::ONE : req_data.x_pos;
               s_in    = {2'b0, p_eff};
               k_in    = 6'd1;
            end
         bsp_pkg::S_KNOT:
            if (k_ff > {1'b0, m_eff}) begin
               kvalid_in = 1'b1;
            end else begin
               prod_in  = 43'(k_ff) << bsp_pkg::FRAC_BITS;
               den_in   = 17'(m_eff) + 17'd1;
               phase_in = bsp_pkg::PH_KNOT;
            end
         bsp_pkg::S_SPAN:
            if ({1'b0, s_ff} < nm1 && kval <= x_ff) begin
               s_in = s_ff + 5'd1;
            end else begin
               for (int i = 0; i < 8; i++) loc_in[i] = '0;
               loc_in[p_eff] = bsp_pkg::ONE;
               j_in    = 3'd1;
               kk_in   = (p_eff == 0) ? 3'd0 : p_eff - 3'd1;
               vsum_in = '0;
               acc_in  = '0;
               e_in    = '0;
            end
         bsp_pkg::S_TA: ta_in = kval;
         bsp_pkg::S_TB: tb_in = kval;
         bsp_pkg::S_TC: tc_in = kval;
         bsp_pkg::S_TD: td_in = kval;
         bsp_pkg::S_M1:
            if (cond1) begin
               prod_in  = mul_p;
               den_in   = tb_ff - ta_ff;
               phase_in = bsp_pkg::PH_T1;
            end
         bsp_pkg::S_M2:
            if (cond2) begin
               prod_in  = mul_p;
               den_in   = td_ff - tc_ff;
               phase_in = bsp_pkg::PH_T2;
            end
         bsp_pkg::S_DGO: div_req.start = 1'b1;
         bsp_pkg::S_DWAIT:
            if (div_rsp.done) begin
               unique case (phase_ff)
                  bsp_pkg::PH_KNOT: begin
                     kt_we = 1'b1;
                     k_in  = k_ff + 6'd1;
                  end
                  bsp_pkg::PH_T1: vsum_in = {1'b0, div_rsp.quot};
                  default: vsum_in = vsum_ff + {1'b0, div_rsp.quot};
               endcase
            end
         bsp_pkg::S_UPD: begin
            loc_in[kk_ff] = (vsum_ff > {18'b0, bsp_pkg::ONE}) ? bsp_pkg::ONE : vsum_ff[16:0];
            vsum_in = '0;
            if (last_term && last_level) begin
               kk_in = '0;
            end else if (last_term) begin
               j_in  = j_ff + 3'd1;
               kk_in = p_eff - j_ff - 3'd1;
            end else begin
               kk_in = kk_ff + 3'd1;
            end
         end
         bsp_pkg::S_SUMM: prod_in = mul_p;
         bsp_pkg::S_SUMA: begin
            acc_in = acc_ff + 46'(prod_ff);
            if (!last_term) kk_in = kk_ff + 3'd1;
         end
         bsp_pkg::S_SUMOUT: begin
            if (q_sh > 46'sd2147483647) rsp_in.curve_value = 32'sh7fffffff;
            else if (q_sh < -46'sd2147483648) rsp_in.curve_value = 32'sh80000000;
            else rsp_in.curve_value = q_sh[31:0];
            rsp_in.basis_value = '0;
            rsp_in.basis_index = '0;
            rsp_in.last        = 1'b1;
            rsp_valid_in       = 1'b1;
         end
         bsp_pkg::S_RSP: if (!rsp_stall) rsp_valid_in = 1'b0;
         bsp_pkg::S_EMIT: begin
            rsp_in.curve_value = '0;
            rsp_in.basis_value = ebasis;
            rsp_in.basis_index = e_ff;
            rsp_in.last        = ({1'b0, e_ff} == nm1);
            rsp_valid_in       = 1'b1;
         end
         bsp_pkg::S_EWAIT:
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               e_in         = e_ff + 5'd1;
            end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsp_pkg::S_IDLE;
         phase_ff     <= bsp_pkg::PH_KNOT;
         degree_ff    <= 3'd3;
         count_ff     <= 6'd8;
         kvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bsp_pkg::MAX_POINTS; i++) table_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         kvalid_ff    <= kvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            kvalid_ff <= 1'b0;
            if (csr_index == bsp_pkg::CSR_DEGREE) degree_ff <= csr_wdata[2:0];
            else count_ff <= csr_wdata;
         end
         if (tbl_we) table_ff[req_data.point_index] <= req_data.point_value;
      end
      if (kt_we) kt_ff[5'(k_ff - 6'd1)] <= kt_in;
      mode_ff <= mode_in;
      x_ff    <= x_in;
      s_ff    <= s_in;
      k_ff    <= k_in;
      e_ff    <= e_in;
      j_ff    <= j_in;
      kk_ff   <= kk_in;
      ta_ff   <= ta_in;
      tb_ff   <= tb_in;
      tc_ff   <= tc_in;
      td_ff   <= td_in;
      loc_ff  <= loc_in;
      vsum_ff <= vsum_in;
      prod_ff <= prod_in;
      den_ff  <= den_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != bsp_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* rtl/bsp_div.sv */
`default_nettype none
module bsp_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsp_pkg::div_req_type div_req,
   output bsp_pkg::div_rsp_type      div_rsp
);

   logic [bsp_pkg::NUM_W-1:0] qn_ff, qn_in;
   logic [16:0]               rem_ff, rem_in;
   logic [16:0]               den_ff, den_in;
   logic [bsp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [17:0]               rem_sh;
   logic                      ge;

   // one restoring step a cycle, quotient bits shift in behind the numerator
   always_comb begin
      rem_sh  = {rem_ff, qn_ff[bsp_pkg::NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      qn_in   = qn_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         qn_in   = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         cnt_in  = bsp_pkg::CNT_W'(bsp_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 17'(rem_sh - {1'b0, den_ff}) : rem_sh[16:0];
         qn_in  = {qn_ff[bsp_pkg::NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qn_ff  <= qn_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = qn_ff;

endmodule
`default_nettype wire

/* rtl/bsp_chk.sv */
`default_nettype none
module bsp_chk (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bsp_pkg::rsp_type rsp_data
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // no new request taken while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with result pending");

   // basis values never exceed one
   a_basis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.basis_value <= bsp_pkg::ONE)
      else $error("basis value above one");

   // final result taken returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid && !req_stall)
      else $error("not idle after final result");

endmodule

bind clamped_bspline_evaluator bsp_chk u_bsp_chk (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
